/* sv/u8u16_pkg.sv */
// Shared types and constants of the UTF-8 to UTF-16LE transcoder.
`default_nettype none
package u8u16_pkg;

  // Character and code point constants
  localparam logic [15:0] REPLACEMENT_UNIT = 16'hfffd;
  localparam logic [15:0] HIGH_SURR_BASE   = 16'hd800;
  localparam logic [15:0] LOW_SURR_BASE    = 16'hdc00;
  localparam logic [15:0] SURR_LAST        = 16'hdfff;
  localparam logic [20:0] SUPPL_BASE       = 21'h10000;
  localparam logic [20:0] CODE_MAX         = 21'h10ffff;
  localparam logic [15:0] THREE_BYTE_MIN   = 16'h0800;
  localparam logic [10:0] TWO_BYTE_MIN     = 11'h080;
  localparam logic [7:0]  CHAR_NUL         = 8'h00;
  localparam logic [7:0]  CHAR_CR          = 8'h0d;
  localparam logic [7:0]  CHAR_LF          = 8'h0a;

  // Sequence lengths announced by a lead byte
  localparam logic [2:0] SEQ_NONE  = 3'd0;
  localparam logic [2:0] SEQ_TWO   = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR  = 3'd4;

  // Most 16-bit units one item can cause, terminator included
  localparam int MAX_UNITS = 5;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // One command: the units to send, low byte first, and the terminator mark
  typedef struct packed {
    logic [MAX_UNITS-1:0][15:0] units;
    logic [2:0]                 n_units;
    logic                       term;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/u8u16_front.sv */
// Front end: decoder state, classification of each item into a unit list.
`default_nettype none
module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       byte_present,
  input  wire logic       end_of_text,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  logic [7:0] pend0, pend1, pend2;
  logic [1:0] pend_count, pend_count_next;
  logic [2:0] seq_len, seq_len_next;
  logic       drop_lf, drop_lf_next;
  logic       after_nul, after_nul_next;

  logic       wr_pend0, wr_pend1, wr_pend2;
  logic [7:0] bb;
  logic [1:0] k_cnt;
  logic [1:0] c_cnt;
  logic [1:0] m_cnt;
  logic       t_flag;
  logic [15:0] code0, code1;
  logic [10:0] v2;
  logic [15:0] v3;
  logic [20:0] v4;
  logic [20:0] adj;
  logic [3:0] b1, b2, b3, total;

  // Decode the item and work out the next state
  always_comb begin
    pend_count_next = pend_count;
    seq_len_next    = seq_len;
    drop_lf_next    = drop_lf;
    after_nul_next  = after_nul;
    wr_pend0 = 1'b0;
    wr_pend1 = 1'b0;
    wr_pend2 = 1'b0;
    k_cnt  = 2'd0;
    c_cnt  = 2'd0;
    m_cnt  = 2'd0;
    t_flag = 1'b0;
    code0  = REPLACEMENT_UNIT;
    code1  = REPLACEMENT_UNIT;
    bb = (text_byte == CHAR_CR) ? CHAR_LF : text_byte;
    v2 = {pend0[4:0], bb[5:0]};
    v3 = {pend0[3:0], pend1[5:0], bb[5:0]};
    v4 = {pend0[2:0], pend1[5:0], pend2[5:0], bb[5:0]};
    adj = v4 - SUPPL_BASE;

    if (byte_present && !after_nul) begin
      if (text_byte == CHAR_NUL) begin
        k_cnt = pend_count;
        pend_count_next = 2'd0;
        seq_len_next    = SEQ_NONE;
        after_nul_next  = 1'b1;
        drop_lf_next    = 1'b0;
      end else if (drop_lf && text_byte == CHAR_LF) begin
        drop_lf_next = 1'b0;
      end else begin
        drop_lf_next = (text_byte == CHAR_CR);
        if (bb[7:6] == 2'b10) begin
          // Continuation byte
          if (pend_count == 2'd0) begin
            c_cnt = 2'd1;
          end else if ({1'b0, pend_count} + 3'd1 >= seq_len) begin
            // Complete sequence: build the code point and check it
            pend_count_next = 2'd0;
            seq_len_next    = SEQ_NONE;
            c_cnt = 2'd1;
            if (seq_len == SEQ_TWO) begin
              if (v2 >= TWO_BYTE_MIN) code0 = {5'd0, v2};
            end else if (seq_len == SEQ_THREE) begin
              if (v3 >= THREE_BYTE_MIN && !(v3 >= HIGH_SURR_BASE && v3 <= SURR_LAST))
                code0 = v3;
            end else begin
              if (v4 >= SUPPL_BASE && v4 <= CODE_MAX) begin
                c_cnt = 2'd2;
                code0 = HIGH_SURR_BASE | {6'd0, adj[19:10]};
                code1 = LOW_SURR_BASE | {6'd0, adj[9:0]};
              end
            end
          end else if (pend_count != 2'd3) begin
            // Hold the continuation
            pend_count_next = pend_count + 2'd1;
            wr_pend1 = (pend_count == 2'd1);
            wr_pend2 = (pend_count == 2'd2);
          end
        end else begin
          // Any other byte flushes what is pending first
          k_cnt = pend_count;
          pend_count_next = 2'd0;
          seq_len_next    = SEQ_NONE;
          if (bb[7] == 1'b0) begin
            c_cnt = 2'd1;
            code0 = {8'd0, bb};
          end else if (bb[7:5] == 3'b110) begin
            seq_len_next = SEQ_TWO;
          end else if (bb[7:4] == 4'b1110) begin
            seq_len_next = SEQ_THREE;
          end else if (bb[7:3] == 5'b11110) begin
            seq_len_next = SEQ_FOUR;
          end else begin
            c_cnt = 2'd1;
          end
          if (bb[7] && bb[7:3] != 5'b11111) begin
            wr_pend0 = 1'b1;
            pend_count_next = 2'd1;
          end
        end
      end
    end

    // End of text: flush what is left, add the terminator, clear state
    if (end_of_text) begin
      m_cnt  = pend_count_next;
      t_flag = 1'b1;
      pend_count_next = 2'd0;
      seq_len_next    = SEQ_NONE;
      drop_lf_next    = 1'b0;
      after_nul_next  = 1'b0;
    end
  end

  // Lay out the unit list: flush, code, flush, terminator
  always_comb begin
    b1 = {2'd0, k_cnt};
    b2 = b1 + {2'd0, c_cnt};
    b3 = b2 + {2'd0, m_cnt};
    total = b3 + {3'd0, t_flag};
    for (int i = 0; i < MAX_UNITS; i++) begin
      if (4'(i) < b1) begin
        cmd.units[i] = REPLACEMENT_UNIT;
      end else if (4'(i) < b2) begin
        cmd.units[i] = (4'(i) == b1) ? code0 : code1;
      end else if (4'(i) < b3) begin
        cmd.units[i] = REPLACEMENT_UNIT;
      end else begin
        cmd.units[i] = 16'h0000;
      end
    end
    cmd.n_units = total[2:0];
    cmd.term    = t_flag;
    cmd_valid   = accept && (total != 4'd0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
      seq_len    <= SEQ_NONE;
      drop_lf    <= 1'b0;
      after_nul  <= 1'b0;
    end else if (accept) begin
      pend_count <= pend_count_next;
      seq_len    <= seq_len_next;
      drop_lf    <= drop_lf_next;
      after_nul  <= after_nul_next;
    end
  end

  // Pending sequence bytes
  always_ff @(posedge clk) begin
    if (accept && wr_pend0) pend0 <= bb;
    if (accept && wr_pend1) pend1 <= bb;
    if (accept && wr_pend2) pend2 <= bb;
  end

endmodule
`default_nettype wire

/* sv/u8u16_queue.sv */
// Command queue between the front end and the byte serializer.
`default_nettype none
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sv/u8u16_back.sv */
// Back end: serializes queued units into bytes through an output register.
`default_nettype none
module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head,
  input  wire logic       empty,
  output logic            pop,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tlast    // last_of_text
);

  logic [3:0]  byte_idx;
  logic [3:0]  last_idx;
  logic [15:0] cur_unit;
  logic        load;

  assign last_idx = {head.n_units, 1'b0} - 4'd1;
  assign cur_unit = head.units[byte_idx[3:1]];
  assign load     = !empty && (!m_tvalid || m_tready);
  assign pop      = load && (byte_idx == last_idx);

  // Step through the bytes of the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= 4'd0;
    end else if (load) begin
      byte_idx <= pop ? 4'd0 : byte_idx + 4'd1;
    end
  end

  // Output register: load a byte, or drop the valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_idx[0] ? cur_unit[15:8] : cur_unit[7:0];
      m_tlast <= head.term && (byte_idx == last_idx);
    end
  end

endmodule
`default_nettype wire

/* sv/utf8_to_utf16le_transcoder_core.sv */
// Top level of the UTF-8 to UTF-16LE transcoder.
//
// Input stream (s_*): one item per handshake; s_tdata carries a UTF-8 byte,
// s_tuser says the byte is present, s_tlast ends the text after the byte.
// Output stream (m_*): UTF-16LE bytes, low byte of each unit first; m_tlast
// marks the second byte of the 0x0000 terminator that closes each text.
// A NUL ends the text early, CR becomes LF and swallows a following LF,
// malformed input yields U+FFFD.
//
// The first byte of an item passes the command queue, then the output
// register. The output delivers one byte per cycle while a command waits and
// the receiver takes it; the front end takes new items while the serializer
// is busy, and items that cause no bytes pass at one per cycle, until the queue fills.
// The front end decodes an item per cycle and writes a unit list into a
// command queue of QUEUE_DEPTH entries; s_tready drops while it is full.
// A stalled receiver holds the output register; the queue keeps filling.
// Reset clears the decoder state, queue and output valid; no clearing pass.
`default_nettype none
module utf8_to_utf16le_transcoder_core
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // text_byte
  input  wire logic       s_tuser,   // byte_present
  input  wire logic       s_tlast,   // end_of_text
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tlast    // last_of_text
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic q_full, q_empty, q_pop;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Decode and classify items
  u8u16_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .text_byte    (s_tdata),
    .byte_present (s_tuser),
    .end_of_text  (s_tlast),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  // Decouple decoding from byte output
  u8u16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .push_cmd (cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  // Serialize units to bytes
  u8u16_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench of the UTF-8 to UTF-16LE transcoder: directed table, random text, byte-level check.
module tb;
  import u8u16_pkg::*;

  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 4;
  localparam int MAX_GAP          = 13;
  localparam int RANDOM_ITEMS     = 344;
  localparam int PAUSE_AFTER      = 150;
  localparam int CALM_FROM        = 200;
  localparam int CALM_TO          = 260;
  localparam int STALL_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int MAX_BEATS        = 10;

  // How the expected bytes of a stimulus row are obtained
  typedef enum logic [1:0] {
    CHK_MODEL,  // from the decoder copy below
    CHK_UNIT,   // one typed-in 16-bit unit
    CHK_TERM    // the terminator alone
  } check_kind_e;

  typedef struct {
    logic [7:0]  text_byte;
    logic        byte_present;
    logic        end_of_text;
    check_kind_e kind;
    logic [15:0] unit;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_text;
  } utf16_beat_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // text_byte
  logic       s_tuser;   // byte_present
  logic       s_tlast;   // end_of_text
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // out_byte
  logic       m_tlast;   // last_of_text

  utf8_to_utf16le_transcoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  text_item_t  text_items[$];
  utf16_beat_t expected_utf16[$];

  // Decoder copy
  logic [7:0] held_bytes [3];
  int         held_count;
  logic [2:0] seq_len;
  bit         cr_seen;
  bit         text_stopped;
  int         item_beats;
  bit         muted;

  int  fail_count;
  int  sent_count;
  int  idle_cycles;
  int  random_made;
  logic calm;

  assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Append one byte, capped at the most bytes one item can cause
  function automatic void emit_byte(input logic [7:0] b, input logic last_flag);
    utf16_beat_t beat;
    beat.out_byte     = b;
    beat.last_of_text = last_flag;
    if (item_beats < MAX_BEATS) begin
      if (!muted)
        expected_utf16 = {expected_utf16, beat};
      item_beats++;
    end
  endfunction

  function automatic void emit_unit(input logic [15:0] u);
    emit_byte(u[7:0], 1'b0);
    emit_byte(u[15:8], 1'b0);
  endfunction

  // Emit a code point, splitting a supplementary one into a surrogate pair
  function automatic void emit_code(input logic [20:0] cp);
    logic [20:0] adj;
    if (cp <= 21'h00ffff) begin
      emit_unit(cp[15:0]);
    end else begin
      adj = cp - SUPPL_BASE;
      emit_unit(HIGH_SURR_BASE + {6'd0, adj[19:10]});
      emit_unit(LOW_SURR_BASE + {6'd0, adj[9:0]});
    end
  endfunction

  // Replace each held byte of a broken sequence
  function automatic void flush_held();
    for (int i = 0; i < held_count; i++)
      emit_unit(REPLACEMENT_UNIT);
    held_count = 0;
    seq_len    = SEQ_NONE;
  endfunction

  function automatic void complete_seq(input logic [7:0] b);
    logic [20:0] v;
    logic [20:0] cp;
    cp = {5'd0, REPLACEMENT_UNIT};
    if (seq_len == SEQ_TWO) begin
      v = {10'd0, held_bytes[0][4:0], b[5:0]};
      if (v >= TWO_BYTE_MIN)
        cp = v;
    end else if (seq_len == SEQ_THREE) begin
      v = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]};
      if (v >= THREE_BYTE_MIN && !(v >= HIGH_SURR_BASE && v <= SURR_LAST))
        cp = v;
    end else begin
      v = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0], b[5:0]};
      if (v >= SUPPL_BASE && v <= CODE_MAX)
        cp = v;
    end
    held_count = 0;
    seq_len    = SEQ_NONE;
    emit_code(cp);
  endfunction

  function automatic void decode_utf8(input logic [7:0] b);
    // Continuation: stray, final or held
    if (b[7:6] == 2'b10) begin
      if (held_count == 0)
        emit_unit(REPLACEMENT_UNIT);
      else if (held_count + 1 >= seq_len)
        complete_seq(b);
      else if (held_count < 3) begin
        held_bytes[held_count] = b;
        held_count++;
      end
      return;
    end
    flush_held();
    if (!b[7]) begin
      emit_unit({8'h00, b});
      return;
    end else if (b[7:5] == 3'b110) begin
      seq_len = SEQ_TWO;
    end else if (b[7:4] == 4'b1110) begin
      seq_len = SEQ_THREE;
    end else if (b[7:3] == 5'b11110) begin
      seq_len = SEQ_FOUR;
    end else begin
      emit_unit(REPLACEMENT_UNIT);
      return;
    end
    held_bytes[0] = b;
    held_count    = 1;
  endfunction

  // Work out the UTF-16LE bytes caused by one accepted item
  function automatic void predict_utf16(input text_item_t it);
    logic [7:0] b;
    b = it.text_byte;
    item_beats = 0;
    if (it.byte_present && !text_stopped) begin
      if (b == CHAR_NUL) begin
        flush_held();
        text_stopped = 1'b1;
        cr_seen      = 1'b0;
      end else if (cr_seen && b == CHAR_LF) begin
        cr_seen = 1'b0;
      end else begin
        cr_seen = 1'b0;
        if (b == CHAR_CR) begin
          cr_seen = 1'b1;
          b       = CHAR_LF;
        end
        decode_utf8(b);
      end
    end
    if (it.end_of_text) begin
      flush_held();
      emit_byte(8'h00, 1'b0);
      emit_byte(8'h00, 1'b1);
      cr_seen      = 1'b0;
      text_stopped = 1'b0;
    end
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic present,
                                  input logic eot, input check_kind_e kind,
                                  input logic [15:0] unit);
    text_item_t it;
    it.text_byte    = b;
    it.byte_present = present;
    it.end_of_text  = eot;
    it.kind         = kind;
    it.unit         = unit;
    text_items = {text_items, it};
  endfunction

  // Queue one random item and count it
  function automatic void add_random(input logic [7:0] b, input logic present,
                                     input logic eot);
    add_row(b, present, eot, CHK_MODEL, 16'h0000);
    random_made++;
  endfunction

  function automatic void add_sequence();
    int          len;
    int          keep;
    logic [20:0] p;
    logic [7:0]  seq [4];
    len = $urandom_range(2, 4);
    case (len)
      2: begin
        p      = 21'($urandom_range(0, 21'h0007ff));
        seq[0] = {3'b110, p[10:6]};
        seq[1] = {2'b10, p[5:0]};
      end
      3: begin
        p      = 21'($urandom_range(0, 21'h00ffff));
        seq[0] = {4'b1110, p[15:12]};
        seq[1] = {2'b10, p[11:6]};
        seq[2] = {2'b10, p[5:0]};
      end
      default: begin
        if ($urandom_range(0, 1) == 1)
          p = 21'($urandom_range(SUPPL_BASE, CODE_MAX));
        else
          p = 21'($urandom_range(0, 21'h1fffff));
        seq[0] = {5'b11110, p[20:18]};
        seq[1] = {2'b10, p[17:12]};
        seq[2] = {2'b10, p[11:6]};
        seq[3] = {2'b10, p[5:0]};
      end
    endcase
    // Cut some sequences short
    keep = ($urandom_range(0, 6) == 0) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < keep; i++)
      add_random(seq[i], 1'b1, 1'b0);
  endfunction

  // Mostly well-formed text with random content, some noise and breaks
  function automatic void fill_random_text();
    int pick;
    random_made = 0;
    while (random_made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        add_random(pick[0] ? CHAR_CR : CHAR_LF, 1'b1, 1'b0);
      else if (pick < 40)
        add_random(8'($urandom_range(1, 127)), 1'b1, 1'b0);
      else if (pick < 75)
        add_sequence();
      else if (pick < 85)
        add_random(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      else if (pick < 88)
        add_random(CHAR_NUL, 1'b1, 1'b0);
      else if (pick < 91)
        add_random(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      else if (pick < 95)
        add_random(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      else
        add_random(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
  endfunction

  function automatic void build_directed();
    add_row(8'h41,     1'b1, 1'b0, CHK_UNIT,  16'h0041);  // first item after reset
    add_row(8'h7f,     1'b1, 1'b0, CHK_UNIT,  16'h007f);  // highest ASCII
    add_row(8'h80,     1'b1, 1'b0, CHK_UNIT,  REPLACEMENT_UNIT);  // stray continuation
    add_row(8'hff,     1'b1, 1'b0, CHK_UNIT,  REPLACEMENT_UNIT);  // invalid lead
    add_row(CHAR_CR,   1'b1, 1'b0, CHK_UNIT,  {8'h00, CHAR_LF});
    add_row(CHAR_LF,   1'b1, 1'b0, CHK_MODEL, 16'h0000);  // swallowed by the CR
    add_row(CHAR_LF,   1'b1, 1'b0, CHK_UNIT,  {8'h00, CHAR_LF});
    add_row(8'hc0,     1'b1, 1'b0, CHK_MODEL, 16'h0000);  // overlong two-byte form
    add_row(8'h80,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'hdf,     1'b1, 1'b0, CHK_MODEL, 16'h0000);  // highest two-byte value
    add_row(8'hbf,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'hed,     1'b1, 1'b0, CHK_MODEL, 16'h0000);  // encoded surrogate
    add_row(8'ha0,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'h80,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'hf4,     1'b1, 1'b0, CHK_MODEL, 16'h0000);  // highest code point
    add_row(8'h8f,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'hbf,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'hbf,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'he2,     1'b1, 1'b0, CHK_MODEL, 16'h0000);  // broken by ASCII
    add_row(8'h41,     1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'he2,     1'b1, 1'b0, CHK_MODEL, 16'h0000);  // broken by NUL
    add_row(CHAR_NUL,  1'b1, 1'b0, CHK_MODEL, 16'h0000);
    add_row(8'h43,     1'b1, 1'b0, CHK_MODEL, 16'h0000);  // ignored after NUL
    add_row(8'hf0,     1'b1, 1'b1, CHK_MODEL, 16'h0000);
    add_row(8'h00,     1'b0, 1'b1, CHK_TERM,  16'h0000);  // end-only, empty text
    add_row(8'hff,     1'b0, 1'b0, CHK_MODEL, 16'h0000);  // empty item
  endfunction

  // Send items
  initial begin
    text_item_t it;
    int         gap;
    int         directed_n;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tuser      = 1'b0;
    s_tlast      = 1'b0;
    fail_count   = 0;
    sent_count   = 0;
    held_count   = 0;
    seq_len      = SEQ_NONE;
    cr_seen      = 1'b0;
    text_stopped = 1'b0;
    muted        = 1'b0;
    build_directed();
    directed_n = text_items.size();
    fill_random_text();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int idx = 0; idx < text_items.size(); idx++) begin
      it = text_items[idx];
      // Hold off until the output has drained once
      if (idx == directed_n + PAUSE_AFTER) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_utf16.size() != 0) @(negedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= it.text_byte;
      s_tuser  <= it.byte_present;
      s_tlast  <= it.end_of_text;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      muted = (it.kind != CHK_MODEL);
      predict_utf16(it);
      muted      = 1'b0;
      item_beats = 0;
      if (it.kind == CHK_UNIT) begin
        emit_unit(it.unit);
      end else if (it.kind == CHK_TERM) begin
        emit_byte(8'h00, 1'b0);
        emit_byte(8'h00, 1'b1);
      end
      sent_count++;
      @(negedge clk);
    end
    s_tvalid <= 1'b0;

    // Drain, then settle
    while (expected_utf16.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_utf16.size() != 0) begin
      $display("%0d expected bytes never arrived", expected_utf16.size());
      fail_count += expected_utf16.size();
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stall the output side at random
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each output byte with the oldest expectation
  always @(posedge clk) begin : check_output
    utf16_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_utf16.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES)
          $display("unexpected byte %02h last %0b", m_tdata, m_tlast);
      end else begin
        want = expected_utf16.pop_front();
        if (m_tdata !== want.out_byte || m_tlast !== want.last_of_text) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES)
            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     want.out_byte, want.last_of_text, m_tdata, m_tlast);
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

/* files.f */
sv/u8u16_pkg.sv
sv/u8u16_front.sv
sv/u8u16_queue.sv
sv/u8u16_back.sv
sv/utf8_to_utf16le_transcoder_core.sv
tb/sv/tb.sv
